// File: rtl/rlpe_pkg.sv
// rlpe_pkg: shared constants and types for the rgb led pulse encoder
// no dependencies; used by rlpe_if.sv and rgb_led_pulse_encoder_top.sv

package rlpe_pkg;

  localparam int CHAN_W            = 8;
  localparam int DUR_W             = 15;
  localparam int LATCH_W           = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 16;
  localparam int DURATION_BITS_DEF = 15;
  localparam int SYMS_PER_PIX      = 24;
  localparam int SYM_CNT_W         = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_ZERO_HIGH  = 3'd1,
    REG_ZERO_LOW   = 3'd2,
    REG_ONE_HIGH   = 3'd3,
    REG_ONE_LOW    = 3'd4,
    REG_LATCH      = 3'd5
  } cfg_reg_t;

  localparam logic [CHAN_W-1:0]  BRIGHTNESS_RST = 8'd255;
  localparam logic [DUR_W-1:0]   ZERO_HIGH_RST  = 15'd3;
  localparam logic [DUR_W-1:0]   ZERO_LOW_RST   = 15'd9;
  localparam logic [DUR_W-1:0]   ONE_HIGH_RST   = 15'd9;
  localparam logic [DUR_W-1:0]   ONE_LOW_RST    = 15'd3;
  localparam logic [LATCH_W-1:0] LATCH_RST      = 16'd500;

endpackage

// File: rtl/rlpe_if.sv
// rlpe_if: valid/ready channels for pixels in and pulse symbols out
// depends on rlpe_pkg

interface rlpe_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rlpe_pkg::CHAN_W-1:0] red;
  logic [rlpe_pkg::CHAN_W-1:0] green;
  logic [rlpe_pkg::CHAN_W-1:0] blue;
  logic                        last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface rlpe_sym_if;
  logic                       valid;
  logic                       ready;
  logic                       first_level;
  logic [rlpe_pkg::DUR_W-1:0] first_ticks;
  logic                       second_level;
  logic [rlpe_pkg::DUR_W-1:0] second_ticks;
  logic                       last_symbol;

  modport source (output valid, first_level, first_ticks, second_level, second_ticks,
                  last_symbol, input ready);
  modport sink   (input valid, first_level, first_ticks, second_level, second_ticks,
                  last_symbol, output ready);
endinterface

// File: rtl/rgb_led_pulse_encoder_top.sv
// rgb_led_pulse_encoder_top: scales a pixel by brightness, emits one pulse symbol per bit
// and a latch symbol at frame end; depends on rlpe_pkg and channel interfaces in rlpe_if.sv
//
// a pixel goes into the pixel register first, then its first symbol into the output register
// throughput: one symbol per cycle unless stalled; 24 symbols per pixel, 25 at a frame end;
//   the single symbol output register sets this, the next pixel is taken during the last symbol
// reset: rst_n synchronous active low, empties the pixel and symbol registers and loads
//   the default brightness and tick counts into the configuration registers

module rgb_led_pulse_encoder_top #(
  parameter int DURATION_BITS = rlpe_pkg::DURATION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rlpe_pix_if.sink                        in_ch,
  rlpe_sym_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rlpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlpe_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DW = rlpe_pkg::DUR_W;
  localparam int CW = rlpe_pkg::CHAN_W;
  localparam int NW = rlpe_pkg::SYM_CNT_W;
  localparam int BITS_W = 3 * CW;
  // largest phase length the line driver can hold
  localparam logic [16:0] DUR_MAX = 17'((64'd1 << DURATION_BITS) - 64'd1);
  localparam logic [NW-1:0] LAST_DATA_IDX = NW'(rlpe_pkg::SYMS_PER_PIX - 1);
  localparam logic [NW-1:0] LATCH_IDX     = NW'(rlpe_pkg::SYMS_PER_PIX);

  // configuration registers
  logic [CW-1:0]                    brightness_r;
  logic [DW-1:0]                    zero_high_r, zero_low_r, one_high_r, one_low_r;
  logic [rlpe_pkg::LATCH_W-1:0]     latch_r;

  // pixel register: scaled bits in send order, shifted out msb first
  logic                             pix_valid_r;
  logic [BITS_W-1:0]                pix_bits_r;
  logic                             pix_last_r;
  logic [NW-1:0]                    sym_idx_r;

  // symbol output register
  logic                             out_valid_r;
  logic                             first_level_r;
  logic [DW-1:0]                    first_ticks_r;
  logic [DW-1:0]                    second_ticks_r;
  logic                             last_symbol_r;

  logic                             sym_adv;
  logic                             pix_done;
  logic                             in_xfer;
  logic                             is_latch;
  logic                             cur_bit;
  logic [DW-1:0]                    first_ticks_nxt;
  logic [DW-1:0]                    second_ticks_nxt;
  logic [DW-1:0]                    half_latch;

  // channel * brightness / 255 truncated; divide by 255 via reciprocal estimate + one fixup
  function automatic logic [CW-1:0] scale(input logic [CW-1:0] c, input logic [CW-1:0] b);
    logic [15:0] prod;
    logic [16:0] sum;
    logic [8:0]  q_est;
    logic [16:0] rem;
    prod  = {8'd0, c} * {8'd0, b};
    sum   = {1'b0, prod} + {9'd0, prod[15:8]};
    q_est = sum[16:8];
    rem   = {1'b0, prod} - (17'(q_est) * 17'd255);
    if (rem >= 17'd255) begin
      q_est = q_est + 9'd1;
    end
    return q_est[CW-1:0];
  endfunction

  // zero goes to one, long values stop at the duration limit
  function automatic logic [DW-1:0] fit(input logic [DW-1:0] t);
    logic [16:0] v;
    v = {2'b00, t};
    if (v == 17'd0) begin
      v = 17'd1;
    end
    if (v > DUR_MAX) begin
      v = DUR_MAX;
    end
    return v[DW-1:0];
  endfunction

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= rlpe_pkg::BRIGHTNESS_RST;
      zero_high_r  <= rlpe_pkg::ZERO_HIGH_RST;
      zero_low_r   <= rlpe_pkg::ZERO_LOW_RST;
      one_high_r   <= rlpe_pkg::ONE_HIGH_RST;
      one_low_r    <= rlpe_pkg::ONE_LOW_RST;
      latch_r      <= rlpe_pkg::LATCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rlpe_pkg::REG_BRIGHTNESS: brightness_r <= cfg_data[CW-1:0];
        rlpe_pkg::REG_ZERO_HIGH:  zero_high_r  <= cfg_data[DW-1:0];
        rlpe_pkg::REG_ZERO_LOW:   zero_low_r   <= cfg_data[DW-1:0];
        rlpe_pkg::REG_ONE_HIGH:   one_high_r   <= cfg_data[DW-1:0];
        rlpe_pkg::REG_ONE_LOW:    one_low_r    <= cfg_data[DW-1:0];
        rlpe_pkg::REG_LATCH:      latch_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // a symbol moves into the output register when a pixel is held and it is empty or being drained
  assign sym_adv  = pix_valid_r && (!out_valid_r || out_ch.ready);
  assign is_latch = (sym_idx_r == LATCH_IDX);
  // pixel finishes on its 24th data symbol, or on the latch symbol for the frame end
  assign pix_done = is_latch || (!pix_last_r && sym_idx_r == LAST_DATA_IDX);
  assign in_ch.ready = !pix_valid_r || (sym_adv && pix_done);
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign cur_bit    = pix_bits_r[BITS_W-1];
  assign half_latch = latch_r[rlpe_pkg::LATCH_W-1:1];

  always_comb begin
    if (is_latch) begin
      first_ticks_nxt  = fit(half_latch);
      second_ticks_nxt = fit(half_latch);
    end else if (cur_bit) begin
      first_ticks_nxt  = fit(one_high_r);
      second_ticks_nxt = fit(one_low_r);
    end else begin
      first_ticks_nxt  = fit(zero_high_r);
      second_ticks_nxt = fit(zero_low_r);
    end
  end

  // pixel register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
      sym_idx_r   <= '0;
    end else if (in_xfer) begin
      pix_valid_r <= 1'b1;
      sym_idx_r   <= '0;
    end else if (sym_adv) begin
      if (pix_done) begin
        pix_valid_r <= 1'b0;
      end
      sym_idx_r <= sym_idx_r + NW'(1);
    end
  end

  // pixel payload: green, red, blue after scaling
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_bits_r <= {scale(in_ch.green, brightness_r), scale(in_ch.red, brightness_r),
                     scale(in_ch.blue, brightness_r)};
      pix_last_r <= in_ch.last_pixel;
    end else if (sym_adv) begin
      pix_bits_r <= {pix_bits_r[BITS_W-2:0], 1'b0};
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sym_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_adv) begin
      first_level_r  <= !is_latch;
      first_ticks_r  <= first_ticks_nxt;
      second_ticks_r <= second_ticks_nxt;
      last_symbol_r  <= pix_done;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.first_level  = first_level_r;
  assign out_ch.first_ticks  = first_ticks_r;
  assign out_ch.second_level = 1'b0;
  assign out_ch.second_ticks = second_ticks_r;
  assign out_ch.last_symbol  = last_symbol_r;

endmodule
